[sv/bcct_pkg.sv]
package bcct_pkg;

	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_OUT_BITS  = 16;

	localparam int UW   = COORD_BITS - 1;
	localparam int VW   = COORD_BITS + 2;
	localparam int LW   = COORD_BITS + 3;
	localparam int MAGW = COORD_BITS + 1;
	localparam int R2W  = COORD_BITS + 1;
	localparam int SQN  = MAGW + 1;
	localparam int OPW  = 2 * SQN;
	localparam int QB   = NORMAL_FRAC_BITS + 2;
	localparam int RW   = SQN + QB;

	localparam logic [1:0] SHAPE_BOX    = 2'd0;
	localparam logic [1:0] SHAPE_CIRCLE = 2'd1;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_BB   = 2'd1;
	localparam logic [1:0] MODE_BC   = 2'd2;
	localparam logic [1:0] MODE_CC   = 2'd3;

	typedef logic signed [COORD_BITS-1:0]      coord_t;
	typedef logic [UW-1:0]                     size_t;
	typedef logic signed [NORMAL_OUT_BITS-1:0] normal_t;

	localparam normal_t NORMAL_ONE = NORMAL_OUT_BITS'(1) << NORMAL_FRAC_BITS;
	localparam logic [QB-1:0] Q_ONE = QB'(1) << NORMAL_FRAC_BITS;

	localparam logic signed [LW:0] PEN_HI = {{(LW-COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [LW:0] PEN_LO = {{(LW-COORD_BITS+2){1'b1}}, {(COORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic                  hit;
		logic                  is_bb;
		coord_t                bb_pen;
		logic                  bb_ny;
		logic [COORD_BITS-1:0] rad;
		logic                  nsx;
		logic                  nsy;
		logic [MAGW-1:0]       magx;
		logic [MAGW-1:0]       magy;
	} sq_carry_t;

	typedef struct packed {
		logic   hit;
		logic   is_bb;
		logic   bb_ny;
		coord_t pen;
		logic   deg;
		logic   nsx;
		logic   nsy;
	} dv_carry_t;

	typedef struct packed {
		logic    hit;
		coord_t  penetration;
		normal_t normal_x;
		normal_t normal_y;
		logic    degenerate;
	} rsp_t;

	function automatic logic [LW-1:0] abs_l(input logic signed [LW-1:0] v);
		return v[LW-1] ? LW'(-v) : LW'(v);
	endfunction

	function automatic coord_t sat_pen(input logic signed [LW:0] v);
		if (v > PEN_HI) return PEN_HI[COORD_BITS-1:0];
		else if (v < PEN_LO) return PEN_LO[COORD_BITS-1:0];
		else return v[COORD_BITS-1:0];
	endfunction

endpackage

[sv/bcct_if.sv]
interface bcct_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          shape_a;
	bcct_pkg::coord_t    centre_ax;
	bcct_pkg::coord_t    centre_ay;
	bcct_pkg::size_t     width_a;
	bcct_pkg::size_t     height_a;
	bcct_pkg::size_t     radius_a;
	logic [1:0]          shape_b;
	bcct_pkg::coord_t    centre_bx;
	bcct_pkg::coord_t    centre_by;
	bcct_pkg::size_t     width_b;
	bcct_pkg::size_t     height_b;
	bcct_pkg::size_t     radius_b;

	modport source(output valid, shape_a, centre_ax, centre_ay, width_a, height_a, radius_a,
		shape_b, centre_bx, centre_by, width_b, height_b, radius_b, input ready);
	modport sink(input valid, shape_a, centre_ax, centre_ay, width_a, height_a, radius_a,
		shape_b, centre_bx, centre_by, width_b, height_b, radius_b, output ready);
endinterface

interface bcct_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	bcct_pkg::coord_t    penetration;
	bcct_pkg::normal_t   normal_x;
	bcct_pkg::normal_t   normal_y;
	logic                degenerate;

	modport source(output valid, hit, penetration, normal_x, normal_y, degenerate, input ready);
	modport sink(input valid, hit, penetration, normal_x, normal_y, degenerate, output ready);
endinterface

[sv/box_circle_collision_test_core.sv]
// Narrow-phase test of one shape pair (box or circle each) per clock while the result side is not
// stalled. The pipeline takes a new item every cycle and passes it through three setup stages (offsets, clamp,
// squares), one stage for the squared-distance compare, 26 stages of a bit-per-stage square root,
// one stage for the circle penetration, 16 stages of two bit-per-stage restoring dividers for the
// normal, then the output register. Square root and dividers set the pipeline depth. When the result
// side stalls, one more item is taken into a skid register before the input drops ready; the whole
// pipeline then holds.
module box_circle_collision_test_core (
	input logic clk,
	input logic arst_n,
	bcct_req_if.sink req,
	bcct_rsp_if.source rsp
);

	localparam int CW  = bcct_pkg::COORD_BITS;
	localparam int NF  = bcct_pkg::NORMAL_FRAC_BITS;
	localparam int NOW = bcct_pkg::NORMAL_OUT_BITS;
	localparam int VW  = bcct_pkg::VW;
	localparam int LW  = bcct_pkg::LW;
	localparam int MAGW = bcct_pkg::MAGW;
	localparam int R2W = bcct_pkg::R2W;
	localparam int SQN = bcct_pkg::SQN;
	localparam int OPW = bcct_pkg::OPW;
	localparam int QB  = bcct_pkg::QB;
	localparam int RW  = bcct_pkg::RW;

	logic en;
	logic skid_v_q;
	bcct_pkg::rsp_t skid_q;

	assign en = !skid_v_q;
	assign req.ready = en;

	// stage 1: roles and doubled offsets
	logic swap;
	logic [1:0] mode_c;
	bcct_pkg::coord_t p_x, p_y, q_x, q_y;
	bcct_pkg::size_t box_w, box_h, circ_r;
	logic [CW-1:0] sw_c, sh_c, rad_c;
	logic signed [VW-1:0] vx_c, vy_c;

	assign swap = (req.shape_a == bcct_pkg::SHAPE_CIRCLE) && (req.shape_b == bcct_pkg::SHAPE_BOX);

	always_comb begin
		priority if (req.shape_a == bcct_pkg::SHAPE_BOX && req.shape_b == bcct_pkg::SHAPE_BOX) begin
			mode_c = bcct_pkg::MODE_BB;
		end else if ((req.shape_a == bcct_pkg::SHAPE_BOX && req.shape_b == bcct_pkg::SHAPE_CIRCLE)
			|| swap) begin
			mode_c = bcct_pkg::MODE_BC;
		end else if (req.shape_a == bcct_pkg::SHAPE_CIRCLE
			&& req.shape_b == bcct_pkg::SHAPE_CIRCLE) begin
			mode_c = bcct_pkg::MODE_CC;
		end else begin
			mode_c = bcct_pkg::MODE_NONE;
		end
	end

	assign p_x = swap ? req.centre_bx : req.centre_ax;
	assign p_y = swap ? req.centre_by : req.centre_ay;
	assign q_x = swap ? req.centre_ax : req.centre_bx;
	assign q_y = swap ? req.centre_ay : req.centre_by;
	assign box_w = swap ? req.width_b : req.width_a;
	assign box_h = swap ? req.height_b : req.height_a;
	assign circ_r = swap ? req.radius_a : req.radius_b;

	assign vx_c = (VW'(q_x) - VW'(p_x)) <<< 1;
	assign vy_c = (VW'(q_y) - VW'(p_y)) <<< 1;
	assign sw_c = (mode_c == bcct_pkg::MODE_BB) ? CW'(req.width_a) + CW'(req.width_b) : CW'(box_w);
	assign sh_c = (mode_c == bcct_pkg::MODE_BB) ? CW'(req.height_a) + CW'(req.height_b)
		: CW'(box_h);
	assign rad_c = (mode_c == bcct_pkg::MODE_CC) ? CW'(req.radius_a) + CW'(req.radius_b)
		: CW'(circ_r);

	logic v_s1;
	logic [1:0] mode_s1;
	logic signed [VW-1:0] vx_s1, vy_s1;
	logic [CW-1:0] sw_s1, sh_s1, rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_c;
			vx_s1 <= vx_c;
			vy_s1 <= vy_c;
			sw_s1 <= sw_c;
			sh_s1 <= sh_c;
			rad_s1 <= rad_c;
		end
	end

	// stage 2: box overlap and per-axis offsets
	function automatic logic signed [LW-1:0] axis_off(input logic signed [LW-1:0] v,
		input logic signed [LW-1:0] w, input logic [1:0] mode);
		logic signed [LW-1:0] r;
		r = v;
		unique case (mode)
			bcct_pkg::MODE_BB: r = (v > 0) ? v - w : ((v < 0) ? v + w : '0);
			bcct_pkg::MODE_BC: r = (v > w) ? v - w : ((v < -w) ? v + w : '0);
			bcct_pkg::MODE_CC: r = v;
			default: r = '0;
		endcase
		return r;
	endfunction

	logic signed [LW-1:0] vxl, vyl, swl, shl;
	logic ovl_c;

	assign vxl = LW'(vx_s1);
	assign vyl = LW'(vy_s1);
	assign swl = signed'(LW'(sw_s1));
	assign shl = signed'(LW'(sh_s1));
	assign ovl_c = (bcct_pkg::abs_l(vxl) < LW'(sw_s1)) && (bcct_pkg::abs_l(vyl) < LW'(sh_s1));

	logic v_s2, ovl_s2;
	logic [1:0] mode_s2;
	logic signed [LW-1:0] lx_s2, ly_s2;
	logic [CW-1:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			ovl_s2 <= ovl_c;
			lx_s2 <= axis_off(vxl, swl, mode_s1);
			ly_s2 <= axis_off(vyl, shl, mode_s1);
			rad_s2 <= rad_s1;
		end
	end

	// stage 3: squares and box penetration
	logic [MAGW-1:0] magx_c, magy_c;
	logic [R2W-1:0] r2_c;
	logic bb_sel;
	logic signed [LW-1:0] bb_v;

	assign magx_c = MAGW'(bcct_pkg::abs_l(lx_s2));
	assign magy_c = MAGW'(bcct_pkg::abs_l(ly_s2));
	assign r2_c = {rad_s2, 1'b0};
	assign bb_sel = bcct_pkg::abs_l(lx_s2) < bcct_pkg::abs_l(ly_s2);
	assign bb_v = bb_sel ? lx_s2 : ly_s2;

	logic v_s3, ovl_s3, bb_ny_s3, sx_s3, sy_s3;
	logic [1:0] mode_s3;
	logic [2*MAGW-1:0] sqx_s3, sqy_s3;
	logic [2*R2W-1:0] rr_s3;
	bcct_pkg::coord_t bb_pen_s3;
	logic [CW-1:0] rad_s3;
	logic [MAGW-1:0] magx_s3, magy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			ovl_s3 <= ovl_s2;
			sqx_s3 <= magx_c * magx_c;
			sqy_s3 <= magy_c * magy_c;
			rr_s3 <= r2_c * r2_c;
			bb_pen_s3 <= bcct_pkg::sat_pen((LW+1)'(bb_v >>> 1));
			bb_ny_s3 <= bb_sel;
			rad_s3 <= rad_s2;
			magx_s3 <= magx_c;
			magy_s3 <= magy_c;
			sx_s3 <= lx_s2[LW-1];
			sy_s3 <= ly_s2[LW-1];
		end
	end

	// squared distance compare, then square root one bit per stage
	logic [OPW-1:0] d2_c;
	logic chit_c, neg_c;
	bcct_pkg::sq_carry_t sq_in_c;

	assign d2_c = OPW'(sqx_s3) + OPW'(sqy_s3);
	assign chit_c = d2_c < OPW'(rr_s3);
	assign neg_c = (mode_s3 == bcct_pkg::MODE_BC);

	always_comb begin
		sq_in_c.hit = (mode_s3 == bcct_pkg::MODE_BB) ? ovl_s3
			: (((mode_s3 == bcct_pkg::MODE_BC) || (mode_s3 == bcct_pkg::MODE_CC)) && chit_c);
		sq_in_c.is_bb = (mode_s3 == bcct_pkg::MODE_BB);
		sq_in_c.bb_pen = bb_pen_s3;
		sq_in_c.bb_ny = bb_ny_s3;
		sq_in_c.rad = rad_s3;
		sq_in_c.nsx = sx_s3 ^ neg_c;
		sq_in_c.nsy = sy_s3 ^ neg_c;
		sq_in_c.magx = magx_s3;
		sq_in_c.magy = magy_s3;
	end

	logic sq_v [0:SQN];
	logic [OPW-1:0] sq_op [0:SQN];
	logic [OPW-1:0] sq_res [0:SQN];
	bcct_pkg::sq_carry_t sq_c [0:SQN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (en) sq_v[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_op[0] <= d2_c;
			sq_res[0] <= '0;
			sq_c[0] <= sq_in_c;
		end
	end

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		localparam int SH = 2 * (SQN - 1 - k);
		logic [OPW-1:0] one, trial;
		logic take;

		assign one = OPW'(1) << SH;
		assign trial = sq_res[k] + one;
		assign take = sq_op[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else if (en) sq_v[k+1] <= sq_v[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_op[k+1] <= take ? sq_op[k] - trial : sq_op[k];
				sq_res[k+1] <= take ? (sq_res[k] >> 1) + one : sq_res[k] >> 1;
				sq_c[k+1] <= sq_c[k];
			end
		end
	end

	// circle penetration, then normal division one quotient bit per stage
	logic [SQN-1:0] root_c;
	logic signed [LW:0] pen_circ_c;
	bcct_pkg::dv_carry_t dv_in_c;

	assign root_c = sq_res[SQN][SQN-1:0];
	assign pen_circ_c = signed'((LW+1)'(sq_c[SQN].rad)) - signed'((LW+1)'(root_c >> 1));

	always_comb begin
		dv_in_c.hit = sq_c[SQN].hit;
		dv_in_c.is_bb = sq_c[SQN].is_bb;
		dv_in_c.bb_ny = sq_c[SQN].bb_ny;
		dv_in_c.pen = sq_c[SQN].is_bb ? sq_c[SQN].bb_pen : bcct_pkg::sat_pen(pen_circ_c);
		dv_in_c.deg = (root_c == '0);
		dv_in_c.nsx = sq_c[SQN].nsx;
		dv_in_c.nsy = sq_c[SQN].nsy;
	end

	logic dv_v [0:QB];
	logic [RW-1:0] dv_rx [0:QB];
	logic [RW-1:0] dv_ry [0:QB];
	logic [QB-1:0] dv_qx [0:QB];
	logic [QB-1:0] dv_qy [0:QB];
	logic [SQN-1:0] dv_s [0:QB];
	bcct_pkg::dv_carry_t dv_c [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= sq_v[SQN];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rx[0] <= RW'(sq_c[SQN].magx) << NF;
			dv_ry[0] <= RW'(sq_c[SQN].magy) << NF;
			dv_qx[0] <= '0;
			dv_qy[0] <= '0;
			dv_s[0] <= root_c;
			dv_c[0] <= dv_in_c;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [RW-1:0] dsh;
		logic tx, ty;

		assign dsh = RW'(dv_s[j]) << B;
		assign tx = dv_rx[j] >= dsh;
		assign ty = dv_ry[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rx[j+1] <= tx ? dv_rx[j] - dsh : dv_rx[j];
				dv_ry[j+1] <= ty ? dv_ry[j] - dsh : dv_ry[j];
				dv_qx[j+1] <= tx ? dv_qx[j] | (QB'(1) << B) : dv_qx[j];
				dv_qy[j+1] <= ty ? dv_qy[j] | (QB'(1) << B) : dv_qy[j];
				dv_s[j+1] <= dv_s[j];
				dv_c[j+1] <= dv_c[j];
			end
		end
	end

	// result assembly
	logic [QB-1:0] qxm, qym;
	bcct_pkg::normal_t unx, uny;
	bcct_pkg::rsp_t res_c;

	assign qxm = (dv_qx[QB] > bcct_pkg::Q_ONE) ? bcct_pkg::Q_ONE : dv_qx[QB];
	assign qym = (dv_qy[QB] > bcct_pkg::Q_ONE) ? bcct_pkg::Q_ONE : dv_qy[QB];
	assign unx = dv_c[QB].nsx ? -NOW'(qxm) : NOW'(qxm);
	assign uny = dv_c[QB].nsy ? -NOW'(qym) : NOW'(qym);

	always_comb begin
		res_c = '0;
		priority if (!dv_c[QB].hit) begin
			res_c = '0;
		end else if (dv_c[QB].is_bb) begin
			res_c.hit = 1'b1;
			res_c.penetration = dv_c[QB].pen;
			res_c.normal_x = dv_c[QB].bb_ny ? '0 : bcct_pkg::NORMAL_ONE;
			res_c.normal_y = dv_c[QB].bb_ny ? bcct_pkg::NORMAL_ONE : '0;
		end else if (dv_c[QB].deg) begin
			res_c.hit = 1'b1;
			res_c.penetration = dv_c[QB].pen;
			res_c.degenerate = 1'b1;
		end else begin
			res_c.hit = 1'b1;
			res_c.penetration = dv_c[QB].pen;
			res_c.normal_x = unx;
			res_c.normal_y = uny;
		end
	end

	logic o_v_s4;
	bcct_pkg::rsp_t o_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o_v_s4 <= 1'b0;
		else if (en) o_v_s4 <= dv_v[QB];
	end

	always_ff @(posedge clk) begin
		if (en) o_s4 <= res_c;
	end

	// skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (rsp.ready) skid_v_q <= 1'b0;
		end else if (o_v_s4 && !rsp.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) skid_q <= o_s4;
	end

	bcct_pkg::rsp_t out_c;
	assign out_c = skid_v_q ? skid_q : o_s4;

	assign rsp.valid = skid_v_q | o_v_s4;
	assign rsp.hit = out_c.hit;
	assign rsp.penetration = out_c.penetration;
	assign rsp.normal_x = out_c.normal_x;
	assign rsp.normal_y = out_c.normal_y;
	assign rsp.degenerate = out_c.degenerate;

	a_deg_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.degenerate |-> rsp.hit)
		else $error("degenerate without hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.penetration == '0 && rsp.normal_x == '0
			&& rsp.normal_y == '0 && !rsp.degenerate)
		else $error("miss carries nonzero fields");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_v_q && o_v_s4 && !rsp.ready |=> skid_v_q && !req.ready)
		else $error("stalled item not held in skid");

endmodule
